// File: rtl/tk_pkg.sv
// ----------------------------------------------------------------------------
// tk_pkg
// Shared types and constants for the top-k distinct value tracker.
// ----------------------------------------------------------------------------
package tk_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int VAL_W       = 32;
  localparam int RANK_W      = 6;
  localparam int KEEP_W      = 7;
  localparam int KEEP_RESET  = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W       = (KEEP_W > CNT_W) ? KEEP_W : CNT_W;

  // Function codes of an input beat
  typedef enum logic [1:0] {
    FUNC_OFFER = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } tk_func_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ROTATE
  } tk_state_t;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [VAL_W-1:0] value;
  } tk_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_res;
    logic [RANK_W-1:0]       rank;
    logic                    last;
    logic                    empty_res;
  } tk_out_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                    ins;
    logic                    rot;
    logic signed [VAL_W-1:0] val;
  } tk_cell_ctrl_t;

endpackage

// File: rtl/tk_cell.sv
// ----------------------------------------------------------------------------
// tk_cell
// One slot of the sorted chain: holds a value, compares it with the offered
// value, and takes it or its left neighbor's on insert, its right on rotate.
// ----------------------------------------------------------------------------
module tk_cell (
  input  logic                           clk,
  input  tk_pkg::tk_cell_ctrl_t          ctrl,
  input  logic                           valid,
  input  logic                           left_gt,
  input  logic signed [tk_pkg::VAL_W-1:0] left_val,
  input  logic signed [tk_pkg::VAL_W-1:0] right_val,
  output logic signed [tk_pkg::VAL_W-1:0] val_o,
  output logic                           gt_o,
  output logic                           eq_o
);
  import tk_pkg::*;

  logic signed [VAL_W-1:0] val_r;
  logic signed [VAL_W-1:0] val_nxt;

  // Compare held entry against the offered value
  assign gt_o  = valid && (val_r > ctrl.val);
  assign eq_o  = valid && (val_r == ctrl.val);
  assign val_o = val_r;

  // Keep larger entries, drop the new value in at the boundary, shift the rest
  always_comb begin
    val_nxt = val_r;
    if (ctrl.rot) begin
      val_nxt = right_val;
    end else if (ctrl.ins && !gt_o) begin
      val_nxt = left_gt ? ctrl.val : left_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: rtl/tk_chain.sv
// ----------------------------------------------------------------------------
// tk_chain
// Row of sorted cells with the duplicate and full-table drop decision.
// Supports shift-insert of an offered value and a full ring rotation.
// ----------------------------------------------------------------------------
module tk_chain (
  input  logic                            clk,
  input  logic                            offer,
  input  logic                            rot,
  input  logic signed [tk_pkg::VAL_W-1:0] value,
  input  logic [tk_pkg::CNT_W-1:0]        count,
  input  logic                            full,
  output logic signed [tk_pkg::VAL_W-1:0] head_val,
  output logic                            grow
);
  import tk_pkg::*;

  logic signed [VAL_W-1:0] cell_val [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  valid_vec;
  logic [MAX_ENTRIES-1:0]  gt_vec;
  logic [MAX_ENTRIES-1:0]  eq_vec;
  logic                    dup;
  logic                    no_room;
  logic                    take;
  tk_cell_ctrl_t           ctrl;

  // Drop duplicates, and values not above the smallest entry of a full table
  assign dup     = |eq_vec;
  assign no_room = full && !(|(valid_vec & ~gt_vec));
  assign take    = offer && !dup && !no_room;
  assign grow    = take && !full;

  assign ctrl.ins = take;
  assign ctrl.rot = rot;
  assign ctrl.val = value;

  assign head_val = cell_val[0];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic                    lgt;
    logic signed [VAL_W-1:0] lval;

    assign valid_vec[g] = (CNT_W'(g) < count);

    if (g == 0) begin : g_head
      assign lgt  = 1'b1;
      assign lval = value;
    end else begin : g_body
      assign lgt  = gt_vec[g-1];
      assign lval = cell_val[g-1];
    end

    tk_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .valid    (valid_vec[g]),
      .left_gt  (lgt),
      .left_val (lval),
      .right_val(cell_val[(g + 1) % MAX_ENTRIES]),
      .val_o    (cell_val[g]),
      .gt_o     (gt_vec[g]),
      .eq_o     (eq_vec[g])
    );
  end

endmodule

// File: rtl/top_k_distinct_tracker_unit.sv
// ----------------------------------------------------------------------------
// top_k_distinct_tracker_unit
// Keeps the k largest distinct signed values in a sorted cell chain and
// streams them out largest first on a read-out request.
// ----------------------------------------------------------------------------
// An offer or a clear beat is accepted back to back: every cell compares
// against the offered value in parallel and the chain shift-inserts it in a
// single step. A read-out holds the input side, also through any output
// stalls: the chain rotates as a ring, one result leaves from the head cell
// each cycle while the output is not stalled, and after the last entry the
// ring keeps turning until it is back in its original order. An empty table
// gives a single empty-marked result. keep_count may be written at any time
// the block is idle; zero acts as 1, and values above 64 act as 64.
module top_k_distinct_tracker_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  tk_pkg::tk_in_t              in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output tk_pkg::tk_out_t             out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tk_pkg::KEEP_W-1:0]   cfg_data
);
  import tk_pkg::*;

  tk_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [KEEP_W-1:0]   keep_r;
  logic [IDX_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  tk_out_t             out_data_r, out_data_nxt;

  logic                in_acc;
  logic                out_free;
  logic                is_last;
  logic                emit;
  logic                rot;
  logic                offer;
  logic                grow;
  logic                full;
  logic [CMP_W-1:0]    k_eff;
  logic signed [VAL_W-1:0] head_val;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign is_last  = (CNT_W'(rd_cnt_r) == (count_r - CNT_W'(1)));
  assign offer    = in_acc && (in_data.func == FUNC_OFFER);

  // Clamp the configured count into one .. MAX_ENTRIES
  always_comb begin
    k_eff = CMP_W'(keep_r);
    if (keep_r == '0) begin
      k_eff = CMP_W'(1);
    end else if (CMP_W'(keep_r) > CMP_W'(MAX_ENTRIES)) begin
      k_eff = CMP_W'(MAX_ENTRIES);
    end
  end
  assign full = (CMP_W'(count_r) >= k_eff);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.func == FUNC_READ)) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free) begin
          if (count_r == '0) begin
            state_nxt = ST_IDLE;
          end else if (is_last) begin
            state_nxt = (rd_cnt_r == IDX_W'(MAX_ENTRIES - 1)) ? ST_IDLE : ST_ROTATE;
          end
        end
      end
      ST_ROTATE: begin
        if (rd_cnt_r == IDX_W'(MAX_ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    emit     = 1'b0;
    rot      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_READ: begin
        emit = out_free;
        rot  = out_free && (count_r != '0);
      end
      ST_ROTATE: begin
        rot = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Read index: reset on a read-out request, advance on every rotation
  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    if (state_r == ST_IDLE) begin
      rd_cnt_nxt = '0;
    end else if (rot) begin
      rd_cnt_nxt = rd_cnt_r + IDX_W'(1);
    end
  end

  // Entry count: clear empties, an accepted offer below capacity grows it
  always_comb begin
    count_nxt = count_r;
    if (in_acc && (in_data.func == FUNC_CLEAR)) begin
      count_nxt = '0;
    end else if (grow) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // Output register: load a beat when the slot is free, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (count_r == '0) begin
        out_data_nxt.value_res = '0;
        out_data_nxt.rank      = '0;
        out_data_nxt.last      = 1'b1;
        out_data_nxt.empty_res = 1'b1;
      end else begin
        out_data_nxt.value_res = head_val;
        out_data_nxt.rank      = RANK_W'(rd_cnt_r);
        out_data_nxt.last      = is_last;
        out_data_nxt.empty_res = 1'b0;
      end
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      keep_r      <= KEEP_W'(KEEP_RESET);
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        keep_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  tk_chain u_chain (
    .clk     (clk),
    .offer   (offer),
    .rot     (rot),
    .value   (in_data.value),
    .count   (count_r),
    .full    (full),
    .head_val(head_val),
    .grow    (grow)
  );

  // The table never holds more than the chain length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(count_r) <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above chain length");

  // The table does not change size while a read-out is under way
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> (count_r == $past(count_r)))
    else $error("entry count changed during read-out");

  // A new result beat only appears out of the read state
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_READ))
    else $error("result beat outside read-out");

  // A last-marked beat ends the read-out
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_data_nxt.last) |=> (state_r != ST_READ))
    else $error("read-out continued after last beat");

endmodule

// File: verif/top_k_distinct_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_distinct_tracker_unit_tb
// Drives offer, read-out, clear and unused-code beats into the top-k tracker.
// A behavioral copy of the sorted table predicts every read-out beat. The run
// moves through several keep_count settings and three idling patterns. A long
// receiver hold-off backs the block up into its input.
// ----------------------------------------------------------------------------
module top_k_distinct_tracker_unit_tb;
  import tk_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = MAX_ENTRIES + 8;
  localparam int LONG_HOLD = 300;
  localparam int MAX_REPORTS = 10;
  localparam int unsigned TIMEOUT_NS = 2_000_000;

  typedef enum logic [1:0] {
    ROW_BEAT,
    ROW_TYPED,
    ROW_KEEP
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    tk_in_t            beat;
    tk_out_t           res;
    logic [KEEP_W-1:0] keep;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tk_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tk_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [KEEP_W-1:0] cfg_data = '0;

  // Shadow of the sorted table and the keep_count register
  logic signed [VAL_W-1:0] held_vals [MAX_ENTRIES];
  int held_cnt = 0;
  int keep_cfg = KEEP_RESET;
  tk_out_t readout_q[$];

  int err_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic hold_pend = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;

  top_k_distinct_tracker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Insert one value into the shadow table, dropping duplicates and losers
  function automatic void offer_value(logic signed [VAL_W-1:0] v);
    int k;
    int pos;
    int i;
    bit full;
    k = keep_cfg;
    if (k < 1) k = 1;
    if (k > MAX_ENTRIES) k = MAX_ENTRIES;
    full = held_cnt >= k;
    pos = 0;
    if (full && (held_cnt == 0 || v <= held_vals[held_cnt-1])) return;
    while (pos < held_cnt && held_vals[pos] > v) pos++;
    if (pos < held_cnt && held_vals[pos] == v) return;
    // a full table loses its smallest entry off the end of the shift
    i = full ? held_cnt - 1 : held_cnt;
    while (i > pos) begin
      held_vals[i] = held_vals[i-1];
      i--;
    end
    held_vals[pos] = v;
    if (!full) held_cnt++;
  endfunction

  // Advance the shadow table by one accepted beat and queue its read-out
  function automatic void track_beat(tk_in_t b, bit typed, tk_out_t typed_res);
    tk_out_t r;
    case (b.func)
      FUNC_OFFER: offer_value(b.value);
      FUNC_CLEAR: held_cnt = 0;
      FUNC_READ: begin
        if (typed) begin
          readout_q.push_back(typed_res);
        end else if (held_cnt == 0) begin
          r = '0;
          r.last = 1'b1;
          r.empty_res = 1'b1;
          readout_q.push_back(r);
        end else begin
          for (int i = 0; i < held_cnt; i++) begin
            r.value_res = held_vals[i];
            r.rank = i[RANK_W-1:0];
            r.last = (i == held_cnt - 1);
            r.empty_res = 1'b0;
            readout_q.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one beat, idling at random first, and track it once accepted
  task automatic send_beat(input tk_in_t b, input bit typed, input tk_out_t typed_res);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    track_beat(b, typed, typed_res);
  endtask

  // Hold the input until every read-out beat is back and the ring settles
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_keep(input logic [KEEP_W-1:0] kv);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= kv;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    keep_cfg = kv;
  endtask

  function automatic dir_row_t beat_row(logic [1:0] f, logic [VAL_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.beat.func = f;
    r.beat.value = v;
    return r;
  endfunction

  // Read-out whose single result is known outright
  function automatic dir_row_t typed_row(logic [VAL_W-1:0] v, logic is_empty);
    dir_row_t r;
    r = '0;
    r.kind = ROW_TYPED;
    r.beat.func = FUNC_READ;
    r.res.value_res = v;
    r.res.last = 1'b1;
    r.res.empty_res = is_empty;
    return r;
  endfunction

  function automatic dir_row_t keep_row(logic [KEEP_W-1:0] kv);
    dir_row_t r;
    r = '0;
    r.kind = ROW_KEEP;
    r.keep = kv;
    return r;
  endfunction

  function automatic tk_in_t rand_beat(int clear_pct);
    tk_in_t b;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) b.func = FUNC_READ;
    else if (sel < 10 + clear_pct) b.func = FUNC_CLEAR;
    else if (sel < 13 + clear_pct) b.func = FUNC_UNUSED;
    else b.func = FUNC_OFFER;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      // narrow band: duplicates and evictions
      b.value = $urandom_range(0, 48) - 24;
    end else if (sel == 3) begin
      b.value = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                             : 32'h8000_0000 + $urandom_range(0, 3);
    end else begin
      b.value = $urandom;
    end
    return b;
  endfunction

  // Receiver: random stall, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_pend && !hold_taken) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Compare each result beat against the oldest predicted one
  always @(posedge clk) begin
    tk_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (readout_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("unexpected result beat: value_res=%0d rank=%0d last=%0b empty=%0b",
                   $signed(out_data.value_res), out_data.rank, out_data.last,
                   out_data.empty_res);
      end else begin
        want = readout_q.pop_front();
        if (out_data.value_res !== want.value_res || out_data.rank !== want.rank ||
            out_data.last !== want.last || out_data.empty_res !== want.empty_res) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("result mismatch: expected value_res=%0d rank=%0d last=%0b empty=%0b,",
                     $signed(want.value_res), want.rank, want.last, want.empty_res,
                     " got value_res=%0d rank=%0d last=%0b empty=%0b",
                     $signed(out_data.value_res), out_data.rank, out_data.last,
                     out_data.empty_res);
        end
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t rows[$];
    tk_in_t b;
    int n_done;
    int seg_keep[7] = '{64, 3, 127, 1, 17, 0, 64};
    int seg_len[7]  = '{110, 25, 50, 20, 45, 20, 30};
    int seg_clr[7]  = '{0, 3, 3, 3, 3, 3, 3};
    int seg_mode[7] = '{0, 0, 1, 1, 2, 2, 2};

    // Directed rows: extremes, duplicates, unused code, keep limits
    rows.push_back(typed_row(32'd0, 1'b1));
    rows.push_back(beat_row(FUNC_OFFER, 32'h7FFF_FFFF));
    rows.push_back(typed_row(32'h7FFF_FFFF, 1'b0));
    rows.push_back(beat_row(FUNC_OFFER, 32'h8000_0000));
    rows.push_back(beat_row(FUNC_OFFER, 32'd0));
    rows.push_back(beat_row(FUNC_OFFER, 32'd0));
    rows.push_back(beat_row(FUNC_OFFER, 32'hFFFF_FFFF));
    rows.push_back(beat_row(FUNC_OFFER, 32'h7FFF_FFFF));
    rows.push_back(beat_row(FUNC_READ, 32'd0));
    rows.push_back(beat_row(FUNC_UNUSED, 32'h5A5A_A5A5));
    rows.push_back(beat_row(FUNC_READ, 32'hFFFF_FFFF));
    rows.push_back(beat_row(FUNC_CLEAR, 32'hFFFF_FFFF));
    rows.push_back(typed_row(32'd0, 1'b1));
    rows.push_back(beat_row(FUNC_OFFER, 32'h8000_0000));
    rows.push_back(typed_row(32'h8000_0000, 1'b0));
    rows.push_back(beat_row(FUNC_OFFER, 32'd100));
    rows.push_back(beat_row(FUNC_OFFER, 32'd50));
    // lower keep below the held count, then offer a winner and a loser
    rows.push_back(keep_row(7'd2));
    rows.push_back(beat_row(FUNC_OFFER, 32'd60));
    rows.push_back(beat_row(FUNC_OFFER, 32'hFFFF_FFFB));
    rows.push_back(beat_row(FUNC_READ, 32'd0));
    // zero keep acts as one
    rows.push_back(keep_row(7'd0));
    rows.push_back(beat_row(FUNC_CLEAR, 32'd0));
    rows.push_back(beat_row(FUNC_OFFER, 32'd10));
    rows.push_back(beat_row(FUNC_OFFER, 32'd20));
    rows.push_back(typed_row(32'd20, 1'b0));

    // Hold reset, then release it
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 20;
    rx_idle_pct = 84;
    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_KEEP:  write_keep(rows[i].keep);
        ROW_TYPED: send_beat(rows[i].beat, 1'b1, rows[i].res);
        default:   send_beat(rows[i].beat, 1'b0, rows[i].res);
      endcase
    end

    // Random segments, one keep setting each
    for (int s = 0; s < 7; s++) begin
      write_keep(seg_keep[s][KEEP_W-1:0]);
      case (seg_mode[s])
        0: begin
          tx_idle_pct = 20;
          rx_idle_pct = 84;
        end
        1: begin
          tx_idle_pct = 84;
          rx_idle_pct = 20;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      // back up the block once while the sender keeps pushing
      if (s == 4) hold_pend <= 1'b1;
      n_done = 0;
      while (n_done < seg_len[s]) begin
        b = rand_beat(seg_clr[s]);
        send_beat(b, 1'b0, '0);
        if (b.func != FUNC_UNUSED) n_done++;
      end
      b = '0;
      b.func = FUNC_READ;
      send_beat(b, 1'b0, '0);
    end

    wait_idle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
